### hw/rtl/normal_map_axis_rotation_assert.svh
// Assertion macros for the normal map axis rotation block.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef NORMAL_MAP_AXIS_ROTATION_ASSERT_SVH
`define NORMAL_MAP_AXIS_ROTATION_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define NMAR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define NMAR_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/nmar_pkg.sv
// Shared types and constants of the normal map axis rotation block.
// No dependencies; used by every RTL module and by nmar_out_if.
package nmar_pkg;

  // Signed Q2.14 value, 1.0 = 16384.
  typedef logic signed [15:0] q14_t;

  localparam q14_t ONE_Q14 = 16'sd16384;

  // Decoded normal vector.
  typedef struct packed {
    q14_t x;
    q14_t y;
    q14_t z;
  } vec_t;

  // Rotation registers as seen by the datapath.
  typedef struct packed {
    q14_t cos_angle;
    q14_t sin_angle;
    q14_t axis_x;
    q14_t axis_y;
    q14_t axis_z;
  } cfg_t;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_COS    = 3'd0,
    CFG_SIN    = 3'd1,
    CFG_AXIS_X = 3'd2,
    CFG_AXIS_Y = 3'd3,
    CFG_AXIS_Z = 3'd4
  } cfg_idx_e;

  // Queue status toward the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Back end control toward the queue and the top level.
  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

endpackage

### hw/rtl/nmar_in_if.sv
// Input channel of the normal map axis rotation block: one packed texel per word.
// No dependencies.
interface nmar_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;

  modport source (output valid, output pixel_rgb, input ready);
  modport sink (input valid, input pixel_rgb, output ready);
endinterface

### hw/rtl/nmar_out_if.sv
// Output channel of the normal map axis rotation block: one rotated normal per word.
// Depends on nmar_pkg for the Q2.14 type.
interface nmar_out_if;
  logic          valid;
  logic          ready;
  nmar_pkg::q14_t out_x;
  nmar_pkg::q14_t out_y;
  nmar_pkg::q14_t out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

### hw/rtl/normal_map_axis_rotation.sv
// Normal map axis rotation: decodes packed texels and rotates them about a unit axis.
// Depends on nmar_pkg, nmar_in_if, nmar_out_if, nmar_front, nmar_queue, nmar_back.
//
// Usage:
//  pix_i carries one packed texel per word (red 23:16, green 15:8, blue 7:0).
//  res_o carries the rotated normal (out_x, out_y, out_z), signed Q2.14, saturated.
//  Software writes cos_angle, sin_angle and axis_x/y/z through cfg_we_i, cfg_idx_i
//  and cfg_data_i while no word is in flight; other indexes are ignored.
//  Throughput: one word per cycle while the receiver takes results; the back end
//  is a five-stage pipeline, and texels are independent of each other.
//  A two-entry queue sits between the decode front and the pipeline.
//  When the receiver stalls, the pipeline and its output register hold, the queue
//  fills, and pix_i.ready falls once the queue is full.
//  Reset clears all valid state and loads cos_angle = 1.0, sin_angle = 0 and a zero
//  axis, which passes decoded texels through unchanged.
`include "normal_map_axis_rotation_assert.svh"

module normal_map_axis_rotation #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nmar_in_if.sink     pix_i,
  nmar_out_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  nmar_pkg::cfg_t       cfg_q;
  nmar_pkg::q_stat_t    q_stat;
  nmar_pkg::back_stat_t back_stat;
  nmar_pkg::vec_t       push_vec;
  nmar_pkg::vec_t       pop_vec;
  logic                 push;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_angle <= nmar_pkg::ONE_Q14;
      cfg_q.sin_angle <= '0;
      cfg_q.axis_x    <= '0;
      cfg_q.axis_y    <= '0;
      cfg_q.axis_z    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nmar_pkg::CFG_COS:    cfg_q.cos_angle <= cfg_data_i;
        nmar_pkg::CFG_SIN:    cfg_q.sin_angle <= cfg_data_i;
        nmar_pkg::CFG_AXIS_X: cfg_q.axis_x    <= cfg_data_i;
        nmar_pkg::CFG_AXIS_Y: cfg_q.axis_y    <= cfg_data_i;
        nmar_pkg::CFG_AXIS_Z: cfg_q.axis_z    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode front end.
  nmar_front u_front (
    .pix_i      (pix_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_vec_o (push_vec)
  );

  // Queue between front and back.
  nmar_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_vec_i (push_vec),
    .pop_i      (back_stat.pop),
    .pop_vec_o  (pop_vec),
    .stat_o     (q_stat)
  );

  // Rotation pipeline and output register.
  nmar_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .q_vec_i  (pop_vec),
    .stat_o   (back_stat),
    .res_o    (res_o)
  );

  // The queue never takes a word while full.
  `NMAR_NEVER(a_no_push_full, push && q_stat.full, "queue written while full")
  // A stalled output register freezes the pipeline, so nothing leaves the queue.
  `NMAR_NEVER(a_no_pop_stall, res_o.valid && !res_o.ready && back_stat.pop, "pop during stall")
  // With nothing queued or in flight, no result can appear.
  `NMAR_ASSERT(a_no_phantom, q_stat.empty && !back_stat.busy && !res_o.valid |=> !res_o.valid, "result from idle block")

endmodule

### hw/rtl/nmar_front.sv
// Front end: accepts texels and decodes each channel to signed Q2.14.
// Depends on nmar_pkg and nmar_in_if; feeds nmar_queue.
module nmar_front (
  nmar_in_if.sink          pix_i,
  input  nmar_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output nmar_pkg::vec_t   push_vec_o
);

  // Channel code c maps to round((2c - 255) * 16384 / 255).
  // The magnitude is 64m + round(64m / 255) with m = |2c - 255|, which is odd.
  // The division by 255 of a value below 65535 is (x + (x >> 8) + 1) >> 8.
  function automatic nmar_pkg::q14_t dec_chan(input logic [7:0] c);
    logic [7:0]  m;
    logic [14:0] lo;
    logic [14:0] qsum;
    logic [6:0]  quo;
    logic [15:0] mag;
    m    = {(c[7] ? c[6:0] : ~c[6:0]), 1'b1};
    lo   = 15'({m, 6'b0}) + 15'd127;
    qsum = lo + 15'(lo >> 8) + 15'd1;
    quo  = qsum[14:8];
    mag  = 16'({m, 6'b0}) + 16'(quo);
    return c[7] ? nmar_pkg::q14_t'(mag) : nmar_pkg::q14_t'(-mag);
  endfunction

  // A word is taken whenever the queue has room.
  assign pix_i.ready = !q_stat_i.full;
  assign push_o      = pix_i.valid && !q_stat_i.full;

  // Red goes to x, green to y, blue to z.
  assign push_vec_o.x = dec_chan(pix_i.pixel_rgb[23:16]);
  assign push_vec_o.y = dec_chan(pix_i.pixel_rgb[15:8]);
  assign push_vec_o.z = dec_chan(pix_i.pixel_rgb[7:0]);

endmodule

### hw/rtl/nmar_queue.sv
// Short queue of decoded vectors between the front and the back end.
// Depends on nmar_pkg.
module nmar_queue #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nmar_pkg::vec_t    push_vec_i,
  input  logic              pop_i,
  output nmar_pkg::vec_t    pop_vec_o,
  output nmar_pkg::q_stat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  nmar_pkg::vec_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage; no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_vec_i;
    end
  end

  assign pop_vec_o    = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(Depth));

endmodule

### hw/rtl/nmar_back.sv
// Back end: five-stage Rodrigues rotation pipeline with rounding, saturation
// and the output register. Depends on nmar_pkg and nmar_out_if.
module nmar_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nmar_pkg::cfg_t       cfg_i,
  input  nmar_pkg::q_stat_t    q_stat_i,
  input  nmar_pkg::vec_t       q_vec_i,
  output nmar_pkg::back_stat_t stat_o,
  nmar_out_if.source           res_o
);

  // The whole pipeline moves when the output register is free or being drained.
  logic adv;
  assign adv = !res_o.valid || res_o.ready;

  // Lane views of the axis and the popped vector.
  logic signed [15:0] ax_l [3];
  logic signed [15:0] v_l  [3];
  logic signed [15:0] cos_l, sin_l;
  logic signed [16:0] omc;

  assign ax_l[0] = $signed(cfg_i.axis_x);
  assign ax_l[1] = $signed(cfg_i.axis_y);
  assign ax_l[2] = $signed(cfg_i.axis_z);
  assign v_l[0]  = $signed(q_vec_i.x);
  assign v_l[1]  = $signed(q_vec_i.y);
  assign v_l[2]  = $signed(q_vec_i.z);
  assign cos_l   = $signed(cfg_i.cos_angle);
  assign sin_l   = $signed(cfg_i.sin_angle);
  assign omc     = 17'(nmar_pkg::ONE_Q14) - 17'(cos_l);

  // Stage valid bits and the output valid.
  logic vld1_q, vld2_q, vld3_q, vld4_q, out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld1_q    <= !q_stat_i.empty;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      out_vld_q <= vld4_q;
    end
  end

  assign stat_o.pop  = adv && !q_stat_i.empty;
  assign stat_o.busy = vld1_q || vld2_q || vld3_q || vld4_q;

  // Per-lane datapath registers.
  logic signed [31:0] pa1_q  [3];
  logic signed [31:0] pb1_q  [3];
  logic signed [31:0] pd1_q  [3];
  logic signed [31:0] vc1_q  [3];
  logic signed [32:0] cr2_q  [3];
  logic signed [31:0] vc2_q  [3];
  logic signed [48:0] cs3_q  [3];
  logic signed [31:0] vc3_q  [3];
  logic signed [52:0] t4_q   [3];
  logic signed [49:0] part4_q [3];
  logic signed [15:0] out_q  [3];

  // Shared rounded dot product and its product with (1 - cos).
  logic signed [19:0] dotq2_q;
  logic signed [36:0] adq3_q;
  logic signed [33:0] dot_sum;

  assign dot_sum = 34'(pd1_q[0]) + 34'(pd1_q[1]) + 34'(pd1_q[2]) + 34'sd8192;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dotq2_q <= 20'(dot_sum >>> 14);
      adq3_q  <= 37'(dotq2_q) * 37'(omc);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    logic signed [53:0] sum;
    logic signed [25:0] rnd;
    logic signed [15:0] sat;

    // Round at bit 28 (bias added in stage 4), then saturate.
    assign sum = 54'(part4_q[i]) + 54'(t4_q[i]);
    assign rnd = 26'(sum >>> 28);

    always_comb begin
      if (rnd > 26'sd32767) begin
        sat = 16'sh7fff;
      end else if (rnd < -26'sd32768) begin
        sat = 16'sh8000;
      end else begin
        sat = 16'(rnd);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // Stage 1: cross, dot and cosine products.
        pa1_q[i]   <= 32'(ax_l[J]) * 32'(v_l[K]);
        pb1_q[i]   <= 32'(ax_l[K]) * 32'(v_l[J]);
        pd1_q[i]   <= 32'(ax_l[i]) * 32'(v_l[i]);
        vc1_q[i]   <= 32'(v_l[i]) * 32'(cos_l);
        // Stage 2: cross product term.
        cr2_q[i]   <= 33'(pa1_q[i]) - 33'(pb1_q[i]);
        vc2_q[i]   <= vc1_q[i];
        // Stage 3: cross times sine.
        cs3_q[i]   <= 49'(cr2_q[i]) * 49'(sin_l);
        vc3_q[i]   <= vc2_q[i];
        // Stage 4: axis term and the partial sum with the rounding bias.
        t4_q[i]    <= 53'(ax_l[i]) * 53'(adq3_q);
        part4_q[i] <= (50'(vc3_q[i]) <<< 14) + 50'(cs3_q[i]) + 50'sd134217728;
        // Output register.
        out_q[i]   <= sat;
      end
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.out_x = out_q[0];
  assign res_o.out_y = out_q[1];
  assign res_o.out_z = out_q[2];

endmodule

### dv/nmar_rotation_checker.sv
// Checker for the normal map axis rotation block: tracks the rotation registers,
// predicts each rotated normal and compares it with the result channel.
// Depends on nmar_pkg, nmar_in_if and nmar_out_if.
`timescale 1ns / 1ps

module nmar_rotation_checker
  import nmar_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  nmar_in_if          pix_i,
  nmar_out_if         res_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          open_cnt_o,
  output int          checked_cnt_o
);

  cfg_t rot_cfg;
  vec_t normals_due [$];
  int   fails;
  int   checked;

  // Rounds a fixed point value down by sh bits, halves toward plus infinity.
  function automatic longint round_half_up(longint x, int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Maps one 8-bit channel to Q2.14, (2c-255)/255 rounded to nearest.
  function automatic longint unit_from_chan(logic [7:0] ch);
    longint num;
    num = (longint'(ch) * 2 - 255) * longint'(ONE_Q14);
    if (num >= 0) return (num + 127) / 255;
    return -((-num + 127) / 255);
  endfunction

  function automatic q14_t clamp_q14(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return q14_t'(v);
  endfunction

  // Decodes a texel and rotates it about the configured axis.
  function automatic vec_t rotate_texel(logic [23:0] rgb, cfg_t c);
    longint vx, vy, vz, ax, ay, az, cs, sn;
    longint cx, cy, cz, dotq, omc, sx, sy, sz;
    vec_t r;
    vx = unit_from_chan(rgb[23:16]);
    vy = unit_from_chan(rgb[15:8]);
    vz = unit_from_chan(rgb[7:0]);
    ax = longint'(c.axis_x);
    ay = longint'(c.axis_y);
    az = longint'(c.axis_z);
    cs = longint'(c.cos_angle);
    sn = longint'(c.sin_angle);
    cx = ay * vz - az * vy;
    cy = az * vx - ax * vz;
    cz = ax * vy - ay * vx;
    // The dot product is brought back to Q2.14 before the (1-cos) term.
    dotq = round_half_up(ax * vx + ay * vy + az * vz, 14);
    omc  = longint'(ONE_Q14) - cs;
    sx = vx * cs * longint'(ONE_Q14) + cx * sn + ax * dotq * omc;
    sy = vy * cs * longint'(ONE_Q14) + cy * sn + ay * dotq * omc;
    sz = vz * cs * longint'(ONE_Q14) + cz * sn + az * dotq * omc;
    r.x = clamp_q14(round_half_up(sx, 28));
    r.y = clamp_q14(round_half_up(sy, 28));
    r.z = clamp_q14(round_half_up(sz, 28));
    return r;
  endfunction

  task automatic check_field(string name, q14_t want, q14_t got);
    if (want !== got) begin
      fails++;
      $display("%0t: out_%s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Results are matched first, then the new texel is predicted, then any register write
  // is applied; the stimulus never overlaps a write with words in flight.
  always @(posedge clk_i or negedge rst_ni) begin
    vec_t want;
    if (!rst_ni) begin
      rot_cfg = '{cos_angle: ONE_Q14, sin_angle: '0, axis_x: '0, axis_y: '0, axis_z: '0};
      normals_due.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (normals_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, expected none, got (%0d, %0d, %0d)", $time,
                   res_i.out_x, res_i.out_y, res_i.out_z);
        end else begin
          want = normals_due.pop_front();
          checked++;
          check_field("x", want.x, res_i.out_x);
          check_field("y", want.y, res_i.out_y);
          check_field("z", want.z, res_i.out_z);
        end
      end
      if (pix_i.valid && pix_i.ready)
        normals_due.insert(normals_due.size(), rotate_texel(pix_i.pixel_rgb, rot_cfg));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COS:    rot_cfg.cos_angle = q14_t'(cfg_data_i);
          CFG_SIN:    rot_cfg.sin_angle = q14_t'(cfg_data_i);
          CFG_AXIS_X: rot_cfg.axis_x = q14_t'(cfg_data_i);
          CFG_AXIS_Y: rot_cfg.axis_y = q14_t'(cfg_data_i);
          CFG_AXIS_Z: rot_cfg.axis_z = q14_t'(cfg_data_i);
          default: ;
        endcase
      end
    end
    fail_cnt_o    <= fails;
    open_cnt_o    <= normals_due.size();
    checked_cnt_o <= checked;
  end

endmodule

### dv/normal_map_axis_rotation_tb.sv
// Top of the normal map axis rotation testbench: clock, reset, texel and register
// stimulus, receiver stalls and the verdict.
// Depends on nmar_pkg, the channel interfaces, the block and nmar_rotation_checker.
`timescale 1ns / 1ps

module normal_map_axis_rotation_tb;
  import nmar_pkg::*;

  localparam int RandomSettings = 10;
  localparam int TexelsPerSetting = 80;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_CHOPPY,
    DRAIN_SLOW
  } drain_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;
  int          fail_cnt;
  int          open_cnt;
  int          checked_cnt;
  int          burst_left;
  int          texels_sent;
  int          settings_cnt;

  nmar_in_if  pix_if ();
  nmar_out_if res_if ();

  normal_map_axis_rotation uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  nmar_rotation_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_if),
    .res_i         (res_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (fail_cnt),
    .open_cnt_o    (open_cnt),
    .checked_cnt_o (checked_cnt)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Writes one register; called at a rising edge, returns at a rising edge.
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Loads a full rotation; writes to the spare indexes first must change nothing.
  task automatic load_rotation(q14_t c, q14_t s, q14_t ax, q14_t ay, q14_t az);
    for (int k = int'(CFG_AXIS_Z) + 1; k < (1 << $bits(cfg_idx)); k++)
      write_reg(3'(k), 16'($urandom));
    write_reg(CFG_COS, c);
    write_reg(CFG_SIN, s);
    write_reg(CFG_AXIS_X, ax);
    write_reg(CFG_AXIS_Y, ay);
    write_reg(CFG_AXIS_Z, az);
    settings_cnt++;
  endtask

  // Register value biased toward the ends and zero of the legal range.
  function automatic q14_t pick_q14();
    case ($urandom_range(0, 5))
      0: return -ONE_Q14;
      1: return ONE_Q14;
      2: return '0;
      default: return q14_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Mostly uniform texels, some built from edge channel codes.
  function automatic logic [23:0] rand_texel();
    logic [23:0] t;
    if ($urandom_range(0, 3) != 0) return 24'($urandom_range(0, 24'hFFFFFF));
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 4))
        0: t[8*k +: 8] = 8'h00;
        1: t[8*k +: 8] = 8'h7F;
        2: t[8*k +: 8] = 8'h80;
        3: t[8*k +: 8] = 8'hFF;
        default: t[8*k +: 8] = 8'($urandom);
      endcase
    end
    return t;
  endfunction

  // Offers one texel and holds it until taken; bursts are separated by random gaps.
  task automatic push_texel(logic [23:0] rgb);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pix_if.valid     <= 1'b1;
    pix_if.pixel_rgb <= rgb;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    texels_sent++;
  endtask

  // Stops offering words and waits until every predicted normal has come back.
  task automatic settle();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (open_cnt != 0) @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    repeat (n) push_texel(rand_texel());
    settle();
  endtask

  // Receiver: free running, choppy and slow stretches of random length.
  initial begin
    drain_mode_e mode;
    int run_left;
    res_if.ready = 1'b0;
    mode = DRAIN_FREE;
    run_left = 0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        mode = drain_mode_e'($urandom_range(0, 2));
        run_left = $urandom_range(16, 160);
      end
      run_left--;
      case (mode)
        DRAIN_FREE:   res_if.ready <= 1'b1;
        DRAIN_CHOPPY: res_if.ready <= ($urandom_range(0, 3) != 0);
        default:      res_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Main stimulus: directed texels and settings, then random rotations.
  initial begin
    logic [23:0] edge_texels [$];
    q14_t c, s;
    int   dir;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_COS;
    cfg_data         = '0;
    pix_if.valid     = 1'b0;
    pix_if.pixel_rgb = '0;
    burst_left       = 0;
    texels_sent      = 0;
    settings_cnt     = 1;
    edge_texels = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F, 24'hFF0000,
                    24'h00FF00, 24'h0000FF, 24'hFF00FF, 24'h7F80FF, 24'h010203,
                    24'hFEFDFC, 24'hAA55AA, 24'h55AA55, 24'h8080FF};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers give the identity, so decoded texels come back unchanged.
    foreach (edge_texels[k]) push_texel(edge_texels[k]);
    settle();

    // Quarter turn about z, half turn about x, and a non-unit axis that saturates.
    load_rotation('0, ONE_Q14, '0, '0, ONE_Q14);
    send_random(3);
    load_rotation(-ONE_Q14, '0, ONE_Q14, '0, '0);
    send_random(3);
    load_rotation(-ONE_Q14, ONE_Q14, ONE_Q14, ONE_Q14, ONE_Q14);
    send_random(3);

    // Random settings: even ones are proper rotations about a signed unit axis,
    // odd ones use arbitrary register values.
    for (int p = 0; p < RandomSettings; p++) begin
      if (p % 2 == 0) begin
        case ($urandom_range(0, 6))
          0: begin c = ONE_Q14;        s = '0;           end
          1: begin c = 16'sd11585;     s = 16'sd11585;   end
          2: begin c = '0;             s = ONE_Q14;      end
          3: begin c = -16'sd11585;    s = 16'sd11585;   end
          4: begin c = -ONE_Q14;       s = '0;           end
          5: begin c = 16'sd14189;     s = 16'sd8192;    end
          default: begin c = 16'sd8192; s = 16'sd14189;  end
        endcase
        dir = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 0)
          load_rotation(c, s, (dir == 0) ? ONE_Q14 : q14_t'(0),
                        (dir == 1) ? ONE_Q14 : q14_t'(0), (dir == 2) ? ONE_Q14 : q14_t'(0));
        else
          load_rotation(c, s, (dir == 0) ? -ONE_Q14 : q14_t'(0),
                        (dir == 1) ? -ONE_Q14 : q14_t'(0), (dir == 2) ? -ONE_Q14 : q14_t'(0));
      end else begin
        load_rotation(pick_q14(), pick_q14(), pick_q14(), pick_q14(), pick_q14());
      end
      send_random(TexelsPerSetting);
    end

    // Identity written back explicitly after arbitrary values.
    load_rotation(ONE_Q14, '0, '0, '0, '0);
    send_random(20);

    repeat (10) @(posedge clk_i);
    $display("Sent %0d texels under %0d rotation settings, including identity, half turns",
             texels_sent, settings_cnt);
    $display("and saturating non-unit axes; %0d rotated normals were compared.", checked_cnt);
    if (fail_cnt == 0) begin
      $display("normal_map_axis_rotation regression: pass");
    end else begin
      $display("normal_map_axis_rotation regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Timed out with %0d normals still outstanding.", open_cnt);
    $display("normal_map_axis_rotation regression: fail");
    $finish;
  end

endmodule
